>>> hw/rtl/tgsr_pkg.sv
`default_nettype none
package tgsr_pkg;

   // grid size
   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 64;
   localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (CELLS > 1) ? $clog2(CELLS) : 1;

   // signed cell coordinates, wide enough for every shape corner
   localparam int COORD_W = 11;
   localparam int USED_W  = COORD_W - 1;
   localparam int LIN_W   = ADDR_W + COORD_W;

   localparam logic [31:0] SPACE_GLYPH = 32'h0000_0020;

   // cell word in RAM: {color, blocked, glyph}
   localparam int CELL_W = 16 + 1 + 32;

   // commands
   localparam logic [1:0] CMD_RECT   = 2'd0;
   localparam logic [1:0] CMD_CIRCLE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // read status codes
   localparam logic [1:0] ST_INSIDE  = 2'd0;
   localparam logic [1:0] ST_BELOW   = 2'd1;
   localparam logic [1:0] ST_OUTSIDE = 2'd2;

   // register indexes
   localparam int          CSR_IDX_W         = 2;
   localparam logic [1:0]  CSR_REGION_WIDTH  = 2'd0;
   localparam logic [1:0]  CSR_REGION_HEIGHT = 2'd1;

   // request payload, pos_x in the lowest bits
   typedef struct packed {
      logic [15:0]       color;
      logic [31:0]       glyph;
      logic              block;
      logic              fill;
      logic [7:0]        arc_rows;
      logic [6:0]        radius;
      logic [7:0]        span_h;
      logic [7:0]        span_w;
      logic signed [8:0] pos_y;
      logic signed [8:0] pos_x;
   } req_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int REQ_TDATA_W = ((REQ_DATA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 32 + 1 + 16;
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;

   // shape description held for one draw
   typedef struct packed {
      logic                     circle;
      logic                     fill;
      logic signed [8:0]        px;
      logic signed [8:0]        py;
      logic [6:0]               r;
      logic [7:0]               arc;
      logic [7:0]               i_last;
      logic [7:0]               j_last;
      logic [13:0]              r2;
      logic [13:0]              in2;
      logic [USED_W-1:0]        used_w;
      logic [USED_W-1:0]        used_h;
   } shape_type;

   // one step of the cell walk
   typedef struct packed {
      logic       active;
      logic [7:0] i;
      logic [7:0] j;
   } step_type;

   function automatic logic inside_region(logic signed [COORD_W-1:0] x,
                                          logic signed [COORD_W-1:0] y,
                                          logic [USED_W-1:0] uw,
                                          logic [USED_W-1:0] uh);
      logic signed [COORD_W-1:0] w_s;
      logic signed [COORD_W-1:0] h_s;
      w_s = $signed({1'b0, uw});
      h_s = $signed({1'b0, uh});
      return (x >= 0) && (x < w_s) && (y >= 0) && (y < h_s);
   endfunction

   // only meaningful for coordinates inside the region
   function automatic logic [ADDR_W-1:0] cell_addr(logic signed [COORD_W-1:0] x,
                                                   logic signed [COORD_W-1:0] y);
      logic [LIN_W-1:0] lin;
      lin = LIN_W'(y[USED_W-1:0]) * LIN_W'(MAX_WIDTH) + LIN_W'(x[USED_W-1:0]);
      return lin[ADDR_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tgsr_ram.sv
`default_nettype none
module tgsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/tgsr_cell_unit.sv
`default_nettype none
module tgsr_cell_unit
   import tgsr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire shape_type         shape,
   input  wire step_type          step,
   output logic                   wr_en_ff,
   output logic [ADDR_W-1:0]      wr_addr_ff
);

   logic signed [COORD_W-1:0] pxe;
   logic signed [COORD_W-1:0] pye;
   logic signed [COORD_W-1:0] x;
   logic signed [COORD_W-1:0] y;
   logic signed [8:0]         dxs;
   logic signed [9:0]         dys;
   logic [6:0]                adx;
   logic [7:0]                ady;
   logic [13:0]               dx2;
   logic [15:0]               dy2;
   logic [16:0]               d2;
   logic                      edge_hit;
   logic                      hit;
   logic                      wr_en_in;
   logic [ADDR_W-1:0]         wr_addr_in;

   always_comb begin
      pxe = {{(COORD_W-9){shape.px[8]}}, shape.px};
      pye = {{(COORD_W-9){shape.py[8]}}, shape.py};

      // distance from the circle center
      dxs = $signed({2'b00, shape.r}) - $signed({1'b0, step.j});
      dys = $signed({2'b00, shape.arc}) - $signed({3'b000, shape.r})
            - $signed({2'b00, step.i});
      adx = dxs[8] ? 7'(-dxs) : dxs[6:0];
      ady = dys[9] ? 8'(-dys) : dys[7:0];
      dx2 = 14'(adx) * 14'(adx);
      dy2 = 16'(ady) * 16'(ady);
      d2  = {3'b000, dx2} + {1'b0, dy2};

      edge_hit = (step.i == 8'd0) || (step.i == shape.i_last) ||
                 (step.j == 8'd0) || (step.j == shape.j_last);

      if (shape.circle) begin
         x = pxe - $signed({4'b0000, shape.r}) + $signed({3'b000, step.j});
         y = pye - $signed({3'b000, shape.arc}) + $signed({4'b0000, shape.r})
             + $signed({3'b000, step.i});
         hit = ({3'b000, shape.r2} >= d2) &&
               (shape.fill || (shape.r == 7'd0) || (d2 >= {3'b000, shape.in2}));
      end else begin
         x = pxe + $signed({3'b000, step.j});
         y = pye + $signed({3'b000, step.i});
         hit = shape.fill || edge_hit;
      end

      wr_en_in   = step.active && hit && inside_region(x, y, shape.used_w, shape.used_h);
      wr_addr_in = cell_addr(x, y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= wr_en_in;
      end
      wr_addr_ff <= wr_addr_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/tile_grid_shape_rasterizer.sv
`default_nettype none
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: cmd; tdata: shape, glyph, color
// rsp      out  rsp_tvalid/rsp_tready  tuser: region_status; tdata: cell fields
// csr      in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// After reset a clearing pass writes every cell (CELLS, 8192 at the default
// grid); no request is taken meanwhile.
// Rectangle and circle draws walk their bounding box row by row; read and empty
// draws skip the walk. One cell is tested per cycle by the shared cell unit and
// written through the single RAM write port.
// The response sits in an output register: a new request is taken while it
// waits, and a finished command holds until the response slot is free.
module tile_grid_shape_rasterizer
   import tgsr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // pos_x, pos_y, span_w, span_h, radius, arc_rows, fill, block, glyph, color
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   // cmd
   input  wire logic [1:0]              req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // cell_glyph, cell_blocked, cell_color
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   // region_status
   output logic [1:0]                   rsp_tuser,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [7:0]              csr_data
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_DRAW  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [7:0]         region_width_ff;
   logic [6:0]         region_height_ff;
   logic [7:0]         i_ff, i_in;
   logic [7:0]         j_ff, j_in;
   shape_type          shape_ff, shape_in;
   logic               block_ff, block_in;
   logic [31:0]        glyph_ff, glyph_in;
   logic [15:0]        color_ff, color_in;
   logic               is_read_ff, is_read_in;
   logic               rd_inside_ff, rd_inside_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   req_data_type              d;
   logic signed [COORD_W-1:0] req_x;
   logic signed [COORD_W-1:0] req_y;
   logic [USED_W-1:0]         used_w;
   logic [USED_W-1:0]         used_h;
   logic [6:0]                r_m1;
   logic                      accept;
   logic                      req_inside;
   step_type                  step;

   logic                      unit_wr_en;
   logic [ADDR_W-1:0]         unit_wr_addr;
   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_waddr;
   logic [CELL_W-1:0]         ram_wdata;
   logic                      ram_re;
   logic [CELL_W-1:0]         ram_rdata;

   assign d      = req_data_type'(req_tdata[REQ_DATA_W-1:0]);
   assign req_x  = {{(COORD_W-9){d.pos_x[8]}}, d.pos_x};
   assign req_y  = {{(COORD_W-9){d.pos_y[8]}}, d.pos_y};
   // region in use, clamped to the grid
   assign used_w = (int'(region_width_ff) < MAX_WIDTH) ? USED_W'(region_width_ff)
                                                       : USED_W'(MAX_WIDTH);
   assign used_h = (int'(region_height_ff) < MAX_HEIGHT) ? USED_W'(region_height_ff)
                                                         : USED_W'(MAX_HEIGHT);
   assign r_m1   = d.radius - 7'd1;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_inside = inside_region(req_x, req_y, used_w, used_h);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign step.active = (state_ff == S_DRAW);
   assign step.i      = i_ff;
   assign step.j      = j_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      shape_in     = shape_ff;
      block_in     = block_ff;
      glyph_in     = glyph_ff;
      color_in     = color_ff;
      is_read_in   = is_read_ff;
      rd_inside_in = rd_inside_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               i_in            = 8'd0;
               j_in            = 8'd0;
               shape_in.circle = (req_tuser == CMD_CIRCLE);
               shape_in.fill   = d.fill;
               shape_in.px     = d.pos_x;
               shape_in.py     = d.pos_y;
               shape_in.r      = d.radius;
               shape_in.arc    = d.arc_rows;
               shape_in.r2     = 14'(d.radius) * 14'(d.radius);
               shape_in.in2    = 14'(r_m1) * 14'(r_m1);
               shape_in.used_w = used_w;
               shape_in.used_h = used_h;
               shape_in.i_last = d.span_h - 8'd1;
               shape_in.j_last = d.span_w - 8'd1;
               block_in        = d.block;
               glyph_in        = d.glyph;
               color_in        = d.color;
               is_read_in      = 1'b0;
               rd_inside_in    = 1'b0;
               status_in       = ST_INSIDE;
               unique case (req_tuser)
                  CMD_RECT: begin
                     if ((d.span_w == 8'd0) || (d.span_h == 8'd0)) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_DRAW;
                     end
                  end
                  CMD_CIRCLE: begin
                     shape_in.i_last = d.arc_rows;
                     shape_in.j_last = {d.radius, 1'b0};
                     state_in        = S_DRAW;
                  end
                  CMD_READ: begin
                     is_read_in   = 1'b1;
                     rd_inside_in = req_inside;
                     if (req_inside) begin
                        status_in = ST_INSIDE;
                     end else if (req_y >= $signed({1'b0, used_h})) begin
                        status_in = ST_BELOW;
                     end else begin
                        status_in = ST_OUTSIDE;
                     end
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DRAW: begin
            // walk the bounding box row by row
            if (j_ff == shape_ff.j_last) begin
               j_in = 8'd0;
               if (i_ff == shape_ff.i_last) begin
                  state_in = S_DONE;
               end else begin
                  i_in = i_ff + 8'd1;
               end
            end else begin
               j_in = j_ff + 8'd1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               if (is_read_ff && rd_inside_ff) begin
                  rsp_data_in = RSP_TDATA_W'(ram_rdata);
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // RAM word order {color, blocked, glyph} matches the response layout
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = {16'h0000, 1'b0, SPACE_GLYPH};
      end else begin
         ram_we    = unit_wr_en;
         ram_waddr = unit_wr_addr;
         ram_wdata = {color_ff, block_ff, glyph_ff};
      end
   end

   assign ram_re = accept && (req_tuser == CMD_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_addr_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         region_width_ff  <= 8'd128;
         region_height_ff <= 7'd64;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_REGION_WIDTH) begin
               region_width_ff <= csr_data;
            end else if (csr_index == CSR_REGION_HEIGHT) begin
               region_height_ff <= csr_data[6:0];
            end
         end
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      shape_ff     <= shape_in;
      block_ff     <= block_in;
      glyph_ff     <= glyph_in;
      color_ff     <= color_in;
      is_read_ff   <= is_read_in;
      rd_inside_ff <= rd_inside_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   tgsr_cell_unit u_cell (
      .clock      (clock),
      .reset      (reset),
      .shape      (shape_ff),
      .step       (step),
      .wr_en_ff   (unit_wr_en),
      .wr_addr_ff (unit_wr_addr)
   );

   tgsr_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (cell_addr(req_x, req_y)),
      .rd_data (ram_rdata)
   );

endmodule
`default_nettype wire

>>> dv/testbench.sv
`default_nettype none
module testbench;
   import tgsr_pkg::*;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam logic [1:0] CSR_SPARE_LO  = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI  = 2'd3;
   localparam int         NUM_PHASES    = 8;
   localparam int         PHASE_ITEMS   = 72;
   localparam int         HOLD_CYCLES   = 600;
   localparam int         DRAIN_CYCLES  = 20;
   localparam int         CYCLE_LIMIT   = 8_000_000;

   // one response as the rsp stream carries it
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] glyph;
      logic        blocked;
      logic [15:0] color;
   } cell_result_type;

   // one line of the directed table
   typedef struct {
      logic [1:0]      cmd;
      req_data_type    data;
      bit              typed;   // result written out by hand
      cell_result_type result;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [1:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [7:0]             csr_data;

   tile_grid_shape_rasterizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // local copy of the grid and of the region registers
   logic [31:0] grid_glyph   [CELLS];
   logic        grid_blocked [CELLS];
   logic [15:0] grid_color   [CELLS];
   logic [7:0]  region_w_reg;
   logic [6:0]  region_h_reg;

   cell_result_type cell_expect_q [$];
   dir_row_type     dir_table [$];

   int  fail_count      = 0;
   int  cycle_count     = 0;
   int  sender_idle_pct = 0;
   int  rsp_stall_pct   = 0;
   bit  hold_arm        = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- grid copy

   function automatic int used_cols();
      return (region_w_reg < MAX_WIDTH) ? int'(region_w_reg) : MAX_WIDTH;
   endfunction

   function automatic int used_rows();
      return (region_h_reg < MAX_HEIGHT) ? int'(region_h_reg) : MAX_HEIGHT;
   endfunction

   function automatic bit in_region(int x, int y);
      return x >= 0 && x < used_cols() && y >= 0 && y < used_rows();
   endfunction

   // writes off the region are dropped, which is the clipping under test
   function automatic void paint(int x, int y, logic [31:0] g, logic b, logic [15:0] c);
      int k;
      if (in_region(x, y)) begin
         k = y * MAX_WIDTH + x;
         grid_glyph[k]   = g;
         grid_blocked[k] = b;
         grid_color[k]   = c;
      end
   endfunction

   // applies one request to the grid copy, returns the response it yields
   function automatic cell_result_type grid_apply(logic [1:0] cmd, req_data_type d);
      cell_result_type res;
      int px, py, sw, sh, r, a, r2, in2, y0, ry, rx, dx, dy, d2, i, j, k;
      bit hit;
      bit on_border;
      res = '0;
      px  = int'($signed(d.pos_x));
      py  = int'($signed(d.pos_y));
      sw  = int'(d.span_w);
      sh  = int'(d.span_h);
      r   = int'(d.radius);
      a   = int'(d.arc_rows);
      case (cmd)
         CMD_RECT: begin
            for (i = 0; i < sh; i++) begin
               for (j = 0; j < sw; j++) begin
                  on_border = (i == 0) || (i == sh - 1) || (j == 0) || (j == sw - 1);
                  if (d.fill || on_border)
                     paint(px + j, py + i, d.glyph, d.block, d.color);
               end
            end
         end
         CMD_CIRCLE: begin
            r2  = r * r;
            in2 = (r - 1) * (r - 1);
            // rows start arc_rows - r above the center and end r below it
            y0  = py - (a - r);
            for (i = 0; i <= a; i++) begin
               ry = y0 + i;
               dy = py - ry;
               for (j = 0; j <= 2 * r; j++) begin
                  rx  = px - r + j;
                  dx  = px - rx;
                  d2  = dx * dx + dy * dy;
                  hit = (d2 <= r2);
                  // ring keeps one cell of thickness; a zero radius ring is the center
                  if (!d.fill && r > 0 && d2 < in2) hit = 1'b0;
                  if (hit) paint(rx, ry, d.glyph, d.block, d.color);
               end
            end
         end
         CMD_READ: begin
            if (in_region(px, py)) begin
               k           = py * MAX_WIDTH + px;
               res.status  = ST_INSIDE;
               res.glyph   = grid_glyph[k];
               res.blocked = grid_blocked[k];
               res.color   = grid_color[k];
            end else if (py >= used_rows()) begin
               res.status = ST_BELOW;
            end else begin
               res.status = ST_OUTSIDE;
            end
         end
         default: ;  // unused command: nothing changes, zero response
      endcase
      return res;
   endfunction

   function automatic void region_write(logic [1:0] idx, logic [7:0] val);
      case (idx)
         CSR_REGION_WIDTH:  region_w_reg = val;
         CSR_REGION_HEIGHT: region_h_reg = val[6:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic dir_row_type dir_row(logic [1:0] cmd, int x, int y, int w, int h,
                                           int r, int a, bit fl, bit bk,
                                           logic [31:0] g, logic [15:0] c, bit typed,
                                           logic [1:0] st, logic [31:0] eg, bit eb,
                                           logic [15:0] ec);
      dir_row_type row;
      row.cmd                = cmd;
      row.data.pos_x         = x[8:0];
      row.data.pos_y         = y[8:0];
      row.data.span_w        = w[7:0];
      row.data.span_h        = h[7:0];
      row.data.radius        = r[6:0];
      row.data.arc_rows      = a[7:0];
      row.data.fill          = fl;
      row.data.block         = bk;
      row.data.glyph         = g;
      row.data.color         = c;
      row.typed              = typed;
      row.result.status      = st;
      row.result.glyph       = eg;
      row.result.blocked     = eb;
      row.result.color       = ec;
      return row;
   endfunction

   function automatic int near_coord(int used);
      return int'($urandom_range(0, used + 16)) - 8;
   endfunction

   // mostly small shapes around the region; now and then one long thin one
   function automatic void rand_item(output logic [1:0] cmd, output req_data_type d);
      int sel, size_sel, rr;
      sel        = int'($urandom_range(0, 99));
      size_sel   = int'($urandom_range(0, 15));
      d.pos_x    = 9'($urandom);
      d.pos_y    = 9'($urandom);
      d.span_w   = 8'($urandom);
      d.span_h   = 8'($urandom);
      d.radius   = 7'($urandom);
      d.arc_rows = 8'($urandom);
      d.fill     = 1'($urandom);
      d.block    = 1'($urandom);
      d.glyph    = $urandom;
      d.color    = 16'($urandom);
      if ($urandom_range(0, 4) != 0) begin
         d.pos_x = 9'(near_coord(used_cols()));
         d.pos_y = 9'(near_coord(used_rows()));
      end
      if (sel < 30) begin
         cmd = CMD_RECT;
         if (size_sel == 0) begin
            d.span_h = 8'($urandom_range(0, 3));
         end else if (size_sel == 1) begin
            d.span_w = 8'($urandom_range(0, 3));
         end else begin
            d.span_w = 8'($urandom_range(0, 12));
            d.span_h = 8'($urandom_range(0, 12));
         end
      end else if (sel < 60) begin
         cmd = CMD_CIRCLE;
         if (size_sel == 0) begin
            d.arc_rows = 8'($urandom_range(0, 2));
         end else if (size_sel == 1) begin
            d.radius = 7'($urandom_range(0, 3));
         end else begin
            d.radius   = 7'($urandom_range(0, 8));
            rr         = int'(d.radius);
            d.arc_rows = 8'($urandom_range(0, 2 * rr + 2));
         end
      end else if (sel < 97) begin
         cmd = CMD_READ;
      end else begin
         cmd = CMD_UNUSED;
      end
      // erase: draw with a space and clear the blocked mark
      if ((cmd == CMD_RECT || cmd == CMD_CIRCLE) && $urandom_range(0, 7) == 0) begin
         d.glyph = SPACE_GLYPH;
         d.block = 1'b0;
      end
   endfunction

   // offers one request, waits for its handshake, then books the response
   task automatic offer(input logic [1:0] cmd, input req_data_type d, input bit typed,
                        input cell_result_type typed_res);
      cell_result_type predicted;
      while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(d);
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = grid_apply(cmd, d);
      cell_expect_q.push_back(typed ? typed_res : predicted);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      region_write(idx, val);
   endtask

   task automatic wait_drained();
      while (cell_expect_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_response();
      cell_result_type want;
      if (cell_expect_q.size() == 0) begin
         $display("%0t: response with no request pending: expected none, actual %0d/%h",
                  $time, rsp_tuser, rsp_tdata);
         fail_count++;
      end else begin
         want = cell_expect_q.pop_front();
         if (rsp_tuser !== want.status) begin
            $display("%0t: region_status expected %0d actual %0d",
                     $time, want.status, rsp_tuser);
            fail_count++;
         end
         if (rsp_tdata[31:0] !== want.glyph) begin
            $display("%0t: cell_glyph expected %h actual %h",
                     $time, want.glyph, rsp_tdata[31:0]);
            fail_count++;
         end
         if (rsp_tdata[32] !== want.blocked) begin
            $display("%0t: cell_blocked expected %b actual %b",
                     $time, want.blocked, rsp_tdata[32]);
            fail_count++;
         end
         if (rsp_tdata[48:33] !== want.color) begin
            $display("%0t: cell_color expected %h actual %h",
                     $time, want.color, rsp_tdata[48:33]);
            fail_count++;
         end
      end
   endtask

   // response side: checks at each handshake and picks rsp_tready for the next
   // cycle; a hold-off, once armed, keeps it low for a long fixed stretch
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_response();
         if (hold_arm) begin
            hold_left = HOLD_CYCLES;
            hold_arm  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------- main flow

   initial begin
      logic [1:0]      cmd;
      req_data_type    d;
      cell_result_type zero_res;
      int              phase_w   [NUM_PHASES];
      int              phase_h   [NUM_PHASES];
      int              phase_snd [NUM_PHASES];
      int              phase_rcv [NUM_PHASES];

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      zero_res   = '0;

      for (int k = 0; k < CELLS; k++) begin
         grid_glyph[k]   = SPACE_GLYPH;
         grid_blocked[k] = 1'b0;
         grid_color[k]   = 16'h0000;
      end
      region_w_reg = 8'd128;
      region_h_reg = 7'd64;

      // directed table, reset region 128 x 64
      // reads of the cleared grid and of every kind of off-map position
      dir_table.push_back(dir_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_INSIDE, SPACE_GLYPH, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 127, 63, 255, 255, 127, 255, 1, 1,
                                  32'hFFFF_FFFF, 16'hFFFF,
                                  1, ST_INSIDE, SPACE_GLYPH, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, -256, -256, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_OUTSIDE, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_BELOW, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 0, 64, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_BELOW, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_OUTSIDE, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, -1, 10, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_OUTSIDE, 0, 0, 0));
      // largest filled rectangle, clipped to the whole grid
      dir_table.push_back(dir_row(CMD_RECT, 0, 0, 255, 255, 0, 0, 1, 1,
                                  32'hFFFF_FFFF, 16'hFFFF, 1, ST_INSIDE, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 127, 63, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_INSIDE, 32'hFFFF_FFFF, 1, 16'hFFFF));
      dir_table.push_back(dir_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_INSIDE, 32'hFFFF_FFFF, 1, 16'hFFFF));
      // zero width and zero height rectangles leave the grid alone
      dir_table.push_back(dir_row(CMD_RECT, 5, 5, 0, 10, 0, 0, 1, 0,
                                  32'h1234_5678, 16'h1234, 1, ST_INSIDE, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_RECT, 5, 5, 10, 0, 0, 0, 1, 0,
                                  32'h1234_5678, 16'h1234, 1, ST_INSIDE, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0,
                                  1, ST_INSIDE, 32'hFFFF_FFFF, 1, 16'hFFFF));
      // outline erase hanging off the top left corner
      dir_table.push_back(dir_row(CMD_RECT, -3, -3, 10, 8, 0, 0, 0, 0,
                                  SPACE_GLYPH, 0, 0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0,
                                  0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 6, 2, 0, 0, 0, 0, 0, 0, 0, 0,
                                  0, 0, 0, 0, 0));
      // zero radius ring draws just the center
      dir_table.push_back(dir_row(CMD_CIRCLE, 60, 30, 0, 0, 0, 0, 0, 0,
                                  32'hAAAA_5555, 16'h5A5A, 0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 60, 30, 0, 0, 0, 0, 0, 0, 0, 0,
                                  0, 0, 0, 0, 0));
      // largest disc
      dir_table.push_back(dir_row(CMD_CIRCLE, 64, 32, 0, 0, 127, 254, 1, 0,
                                  32'h4142_4344, 16'h0F0F, 0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_CIRCLE, 20, 20, 0, 0, 5, 10, 0, 1,
                                  32'h0000_0023, 16'h00C3, 0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 20, 15, 0, 0, 0, 0, 0, 0, 0, 0,
                                  0, 0, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_READ, 20, 20, 0, 0, 0, 0, 0, 0, 0, 0,
                                  0, 0, 0, 0, 0));
      // more rows than the circle is tall: extra rows run off the top
      dir_table.push_back(dir_row(CMD_CIRCLE, 100, 10, 0, 0, 3, 255, 1, 1,
                                  32'h0000_0007, 16'h8000, 0, 0, 0, 0, 0));
      // unused command
      dir_table.push_back(dir_row(CMD_UNUSED, -1, -1, 255, 255, 127, 255, 1, 1,
                                  32'hFFFF_FFFF, 16'hFFFF, 1, ST_INSIDE, 0, 0, 0));
      dir_table.push_back(dir_row(CMD_RECT, 127, 63, 1, 1, 0, 0, 0, 0, 0, 0,
                                  0, 0, 0, 0, 0));

      // region settings and idle pattern of each random phase
      phase_w   = '{128, 1, 255, 0, 37, 0, 128, 100};
      phase_h   = '{64, 1, 255, 0, 21, 0, 64, 50};
      phase_snd = '{0, 81, 0, 23, 0, 81, 0, 23};
      phase_rcv = '{0, 0, 81, 23, 0, 0, 81, 23};
      phase_w[5] = int'($urandom_range(0, 255));
      phase_h[5] = int'($urandom_range(0, 127));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // the grid clear after reset holds off the first request
      @(posedge clock);
      while (!req_tready) @(posedge clock);

      foreach (dir_table[k])
         offer(dir_table[k].cmd, dir_table[k].data, dir_table[k].typed, dir_table[k].result);
      req_tvalid <= 1'b0;
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         // nothing is in flight here, so the region may change
         if (p == 3) begin
            write_reg(CSR_SPARE_LO, 8'($urandom));
            write_reg(CSR_SPARE_HI, 8'($urandom));
         end
         write_reg(CSR_REGION_WIDTH, 8'(phase_w[p]));
         write_reg(CSR_REGION_HEIGHT, 8'(phase_h[p]));
         csr_valid <= 1'b0;
         sender_idle_pct = phase_snd[p];
         rsp_stall_pct   = phase_rcv[p];
         // long response hold-off while requests keep coming: fills the block
         if (p == 4) hold_arm = 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            rand_item(cmd, d);
            offer(cmd, d, 0, zero_res);
            // once, let every outstanding response drain before going on
            if (p == 6 && n == PHASE_ITEMS / 2) begin
               req_tvalid <= 1'b0;
               do @(posedge clock); while (cell_expect_q.size() != 0);
            end
         end
         req_tvalid <= 1'b0;
         wait_drained();
      end

      // catch any stray response after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
